// ===== rtl/utf8tc_pkg.sv =====
// Shared types and constants for the UTF-16/UTF-32 to UTF-8 transcoder.
`timescale 1ns / 1ps

package utf8tc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_BIG_ENDIAN    = 2'd1;
    localparam logic [1:0] REG_VALIDATE      = 2'd2;

    // Source formats
    localparam logic FMT_UTF16 = 1'b0;
    localparam logic FMT_UTF32 = 1'b1;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Code point limits
    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;
    localparam logic [20:0] LIMIT_1BYTE    = 21'h00_0080;
    localparam logic [20:0] LIMIT_2BYTE    = 21'h00_0800;
    localparam logic [20:0] LIMIT_3BYTE    = 21'h01_0000;

    // Surrogate tags in the top six bits of a UTF-16 unit
    localparam logic [5:0] LEAD_TAG  = 6'b110110;
    localparam logic [5:0] TRAIL_TAG = 6'b110111;

    // Lead offset added to a held lead surrogate: 0x10000 >> 10
    localparam logic [10:0] PAIR_OFFSET = 11'd64;

    // UTF-8 byte marks
    localparam logic [7:0] MARK_LEAD2 = 8'hC0;
    localparam logic [7:0] MARK_LEAD3 = 8'hE0;
    localparam logic [7:0] MARK_LEAD4 = 8'hF0;
    localparam logic [7:0] MARK_CONT  = 8'h80;

    // Default queue depth between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Work descriptor handed from front to back
    typedef struct packed {
        logic [20:0] cp;          // code point to encode
        logic [2:0]  nbytes;      // UTF-8 bytes to emit, 0 to 4
        logic        has_status;  // append an end-of-stream status result
        logic        status_code; // code carried by the status result
    } desc_t;

endpackage

// ===== rtl/utf16_utf32_to_utf8_transcoder.sv =====
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
//
//   Channel  Signals                                         Transfer when
//   input    in_valid, in_stall, raw_unit, end_of_stream,    in_valid && !in_stall
//            partial_tail, unit_present
//   output   out_valid, out_stall, out_byte, is_status,      out_valid && !out_stall
//            status_code, last_of_run
//   config   cfg_write, cfg_index, cfg_data                  cfg_write
//
// The back end emits one result per cycle while out_stall is low, so an item yields 0 to 5
// results: its UTF-8 bytes (0 to 4) plus one status result on end of stream.
// The front end takes an item every cycle while the descriptor queue has room;
// its descriptor is registered in the queue, then in cur_reg, then in the output register.
// Reset clears configuration, surrogate and error state and empties the queue at once.
// A stall on the output holds the result register; the queue then fills and
// in_stall rises when it is full.
`timescale 1ns / 1ps

module utf16_utf32_to_utf8_transcoder
#(
    parameter int QUEUE_DEPTH = utf8tc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] raw_unit,
    input  logic        end_of_stream,
    input  logic        partial_tail,
    input  logic        unit_present,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_status,
    output logic        status_code,
    output logic        last_of_run
);

    logic              accept;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    utf8tc_pkg::desc_t push_data;
    utf8tc_pkg::desc_t pop_data;

    // Accept while the queue has room
    assign in_stall = full;
    assign accept   = in_valid && !full;

    utf8tc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .raw_unit      (raw_unit),
        .end_of_stream (end_of_stream),
        .partial_tail  (partial_tail),
        .unit_present  (unit_present),
        .push          (push),
        .push_data     (push_data)
    );

    utf8tc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    utf8tc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_status   (is_status),
        .status_code (status_code),
        .last_of_run (last_of_run)
    );

endmodule

// ===== rtl/utf8tc_front.sv =====
// Front end: configuration, byte swapping, surrogate pairing and classification.
`timescale 1ns / 1ps

module utf8tc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic                cfg_data,
    input  logic                accept,
    input  logic [31:0]         raw_unit,
    input  logic                end_of_stream,
    input  logic                partial_tail,
    input  logic                unit_present,
    output logic                push,
    output utf8tc_pkg::desc_t   push_data
);

    logic       source_format_reg;
    logic       big_endian_reg;
    logic       validate_reg;
    logic [9:0] pending_lead_reg;
    logic [9:0] pending_lead_next;
    logic       lead_waiting_reg;
    logic       lead_waiting_next;
    logic       error_stopped_reg;
    logic       error_stopped_next;

    logic [15:0] unit16;
    logic [31:0] unit32;
    logic        emit;
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic        has_status;
    logic        status_code;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= utf8tc_pkg::FMT_UTF16;
            big_endian_reg    <= 1'b0;
            validate_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                utf8tc_pkg::REG_SOURCE_FORMAT: source_format_reg <= cfg_data;
                utf8tc_pkg::REG_BIG_ENDIAN:    big_endian_reg    <= cfg_data;
                utf8tc_pkg::REG_VALIDATE:      validate_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Swap bytes into numeric order
    assign unit16 = big_endian_reg ? {raw_unit[7:0], raw_unit[15:8]} : raw_unit[15:0];
    assign unit32 = big_endian_reg
                  ? {raw_unit[7:0], raw_unit[15:8], raw_unit[23:16], raw_unit[31:24]}
                  : raw_unit;

    // Decode the unit and update the pairing state
    always_comb
    begin
        pending_lead_next  = pending_lead_reg;
        lead_waiting_next  = lead_waiting_reg;
        error_stopped_next = error_stopped_reg;
        emit               = 1'b0;
        cp                 = {5'd0, unit16};

        if (unit_present && !error_stopped_reg)
        begin
            if (source_format_reg == utf8tc_pkg::FMT_UTF16)
            begin
                priority if (lead_waiting_reg)
                begin
                    lead_waiting_next = 1'b0;
                    pending_lead_next = 10'd0;
                    if (unit16[15:10] == utf8tc_pkg::TRAIL_TAG)
                    begin
                        emit = 1'b1;
                        cp   = {11'(pending_lead_reg) + utf8tc_pkg::PAIR_OFFSET, unit16[9:0]};
                    end
                    else if (validate_reg)
                    begin
                        error_stopped_next = 1'b1;
                    end
                end
                else if (unit16[15:10] == utf8tc_pkg::LEAD_TAG)
                begin
                    pending_lead_next = unit16[9:0];
                    lead_waiting_next = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            else
            begin
                lead_waiting_next = 1'b0;
                pending_lead_next = 10'd0;
                cp                = unit32[20:0];
                if (unit32 > utf8tc_pkg::MAX_CODE_POINT)
                begin
                    if (validate_reg)
                    begin
                        error_stopped_next = 1'b1;
                    end
                end
                else
                begin
                    emit = 1'b1;
                end
            end
        end

        // Close the text and report status
        has_status  = end_of_stream;
        status_code = utf8tc_pkg::STATUS_OK;
        if (end_of_stream)
        begin
            if (validate_reg && (lead_waiting_next || partial_tail))
            begin
                error_stopped_next = 1'b1;
            end
            status_code = error_stopped_next ? utf8tc_pkg::STATUS_INVALID
                                             : utf8tc_pkg::STATUS_OK;
            pending_lead_next  = 10'd0;
            lead_waiting_next  = 1'b0;
            error_stopped_next = 1'b0;
        end
    end

    // Size the UTF-8 sequence
    always_comb
    begin
        priority if (!emit)                        nbytes = 3'd0;
        else if (cp < utf8tc_pkg::LIMIT_1BYTE)      nbytes = 3'd1;
        else if (cp < utf8tc_pkg::LIMIT_2BYTE)      nbytes = 3'd2;
        else if (cp < utf8tc_pkg::LIMIT_3BYTE)      nbytes = 3'd3;
        else                                        nbytes = 3'd4;
    end

    assign push_data = {cp, nbytes, has_status, status_code};
    assign push      = accept && (emit || end_of_stream);

    // Hold pairing and error state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_lead_reg  <= 10'd0;
            lead_waiting_reg  <= 1'b0;
            error_stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_lead_reg  <= pending_lead_next;
            lead_waiting_reg  <= lead_waiting_next;
            error_stopped_reg <= error_stopped_next;
        end
    end

endmodule

// ===== rtl/utf8tc_queue.sv =====
// Short descriptor queue between the front and back ends.
`timescale 1ns / 1ps

module utf8tc_queue
#(
    parameter int DEPTH = utf8tc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utf8tc_pkg::desc_t push_data,
    output logic              full,
    input  logic              pop,
    output utf8tc_pkg::desc_t pop_data,
    output logic              empty
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

    utf8tc_pkg::desc_t  entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + COUNT_W'(1);
            2'b01:   count_next = count_reg - COUNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/utf8tc_back.sv =====
// Back end: serialises each descriptor into UTF-8 bytes and, at end of stream, a status result.
`timescale 1ns / 1ps

module utf8tc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  utf8tc_pkg::desc_t pop_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              is_status,
    output logic              status_code,
    output logic              last_of_run
);

    utf8tc_pkg::desc_t cur_reg;
    logic              cur_valid_reg;
    logic [2:0]        idx_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              is_status_reg;
    logic              status_code_reg;
    logic              last_of_run_reg;

    logic [2:0] total;
    logic [2:0] pos;
    logic       is_data;
    logic       slot_free;
    logic       load;
    logic       last;
    logic       finishing;
    logic [7:0] data_byte;

    assign slot_free = !out_valid_reg || !out_stall;
    assign load      = cur_valid_reg && slot_free;
    assign total     = cur_reg.nbytes + 3'(cur_reg.has_status);
    assign last      = (idx_reg == total - 3'd1);
    assign finishing = load && last;
    assign pop       = !empty && (!cur_valid_reg || finishing);
    assign is_data   = (idx_reg < cur_reg.nbytes);
    assign pos       = cur_reg.nbytes - 3'd1 - idx_reg;

    // Pick the byte for the current slot
    always_comb
    begin
        if (idx_reg == 3'd0)
        begin
            unique case (cur_reg.nbytes)
                3'd1:    data_byte = {1'b0, cur_reg.cp[6:0]};
                3'd2:    data_byte = utf8tc_pkg::MARK_LEAD2 | {3'd0, cur_reg.cp[10:6]};
                3'd3:    data_byte = utf8tc_pkg::MARK_LEAD3 | {4'd0, cur_reg.cp[15:12]};
                default: data_byte = utf8tc_pkg::MARK_LEAD4 | {5'd0, cur_reg.cp[20:18]};
            endcase
        end
        else
        begin
            unique case (pos)
                3'd2:    data_byte = utf8tc_pkg::MARK_CONT | {2'd0, cur_reg.cp[17:12]};
                3'd1:    data_byte = utf8tc_pkg::MARK_CONT | {2'd0, cur_reg.cp[11:6]};
                default: data_byte = utf8tc_pkg::MARK_CONT | {2'd0, cur_reg.cp[5:0]};
            endcase
        end
    end

    // Take the next descriptor and step through its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (finishing)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (slot_free)
            begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= is_data ? data_byte : 8'd0;
            is_status_reg   <= !is_data;
            status_code_reg <= is_data ? utf8tc_pkg::STATUS_OK : cur_reg.status_code;
            last_of_run_reg <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_status   = is_status_reg;
    assign status_code = status_code_reg;
    assign last_of_run = last_of_run_reg;

endmodule

// ===== rtl/utf8tc_checker.sv =====
// Port-level assertions for the transcoder, bound to the top level.
`timescale 1ns / 1ps

module utf8tc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       is_status,
    input logic       status_code,
    input logic       last_of_run
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("output result withdrawn under stall");

    // A stalled result holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_byte) && $stable(is_status))
    else $error("output payload changed under stall");

    // A status result carries a zero byte and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> out_byte == 8'd0 && last_of_run)
    else $error("status result malformed");

    // Data results carry no status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> !status_code)
    else $error("status code set on a data byte");

    // A multi-byte lead byte never closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status && out_byte[7:6] == 2'b11 |-> !last_of_run)
    else $error("run closed on a multi-byte lead byte");

endmodule

bind utf16_utf32_to_utf8_transcoder utf8tc_checker u_checker (.*);
